// ===== rtl/vic_pkg.sv =====
// shared types, register offsets and constants of the vectored interrupt controller
package vic_pkg;

    localparam int unsigned MAX_LINES  = 32;
    localparam int unsigned PRIO_W     = 4;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned S_TDATA_W  = 88;
    localparam int unsigned S_TUSER_W  = 2;
    localparam int unsigned M_TDATA_W  = 72;
    localparam int unsigned PADDR_W    = 3;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_LINE  = 2'd0;
    localparam t_opcode OP_READ  = 2'd1;
    localparam t_opcode OP_WRITE = 2'd2;
    localparam t_opcode OP_CHAIN = 2'd3;

    localparam logic [11:0] OFF_IRQ_STATUS = 12'h000;
    localparam logic [11:0] OFF_FIQ_STATUS = 12'h004;
    localparam logic [11:0] OFF_RAW_STATUS = 12'h008;
    localparam logic [11:0] OFF_FIQ_SELECT = 12'h00c;
    localparam logic [11:0] OFF_ENABLE     = 12'h010;
    localparam logic [11:0] OFF_ENABLE_CLR = 12'h014;
    localparam logic [11:0] OFF_SOFT       = 12'h018;
    localparam logic [11:0] OFF_SOFT_CLR   = 12'h01c;
    localparam logic [11:0] OFF_PROTECT    = 12'h020;
    localparam logic [11:0] OFF_PRIO_MASK  = 12'h024;
    localparam logic [11:0] OFF_CHAIN_PRIO = 12'h028;
    localparam logic [11:0] OFF_VECT_ADDR  = 12'hf00;

    // window tags taken from offset bits 11..7 and 11..5
    localparam logic [4:0] WIN_VECTOR = 5'b00010;
    localparam logic [4:0] WIN_PRIO   = 5'b00100;
    localparam logic [6:0] WIN_ID     = 7'b1111111;

    localparam logic [PADDR_W-1:0] CFG_CHAIN_PRESENT = 3'd0;

    typedef struct packed {
        logic [31:0] chain_vector;
        logic        chain_fiq;
        logic        chain_irq;
        logic        line_level;
        logic [4:0]  line_index;
        logic [31:0] write_data;
        logic [11:0] reg_offset;
    } t_req;

    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h92;
            3'd1:    b = 8'h11;
            3'd2:    b = 8'h04;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0d;
            3'd5:    b = 8'hf0;
            3'd6:    b = 8'h05;
            3'd7:    b = 8'hb1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/vic_ram.sv =====
// generic single write, single read ram with registered read data
module vic_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vectored_interrupt_controller_top.sv =====
// vectored interrupt controller top level: register file, selection tree and nesting stack
// a request passes through the input, process and output registers before its result reaches the output
// one request per cycle unless the output stalls; the selection tree over all lines is combinational
// an output stall holds every stage and the state, and tready drops with it
// reset (synchronous, active low) sets masks and levels to zero, priorities to fifteen,
// the priority mask to all ones and the nesting stack to empty; vector table reads zero
module vectored_interrupt_controller_top #(
    parameter int unsigned NUM_LINES  = 32,
    parameter int unsigned NUM_LEVELS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // reg_offset, write_data, line_index, line_level, chain_irq, chain_fiq, chain_vector
    input  logic [vic_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // opcode
    input  logic [vic_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_data, irq_out, fiq_out, pending_vector, chain_ack, bad_access
    output logic [vic_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vic_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import vic_pkg::*;

    localparam int unsigned LVL_W = $clog2(NUM_LEVELS + 1);
    localparam logic [31:0] LINE_MASK = 32'hffffffff >> (32 - NUM_LINES);
    localparam logic [LVL_W-1:0] NO_LEVEL = LVL_W'(NUM_LEVELS);

    // configuration
    logic r_chain_present;

    // interrupt state
    logic [31:0]       r_line_levels, r_soft_levels, r_enable, r_fast_sel;
    logic [PRIO_W-1:0] r_prio [MAX_LINES];
    logic [15:0]       r_prio_mask;
    logic [PRIO_W-1:0] r_chain_prio;
    logic              r_protect;
    logic [LVL_W-1:0]  r_active;
    logic [LVL_W-1:0]  r_stack [NUM_LEVELS];
    logic [LVL_W-1:0]  r_depth;
    logic [31:0]       r_last_vec;
    logic              r_chain_irq, r_chain_fiq;
    logic [31:0]       r_chain_addr;

    // pipeline
    logic        r_in_valid;
    t_opcode     r_in_op;
    t_req        r_in;
    logic        r_in_byp;
    logic [31:0] r_byp_data;
    logic        r_mid_valid, r_mid_use_q, r_mid_ack, r_mid_bad;
    logic [31:0] r_mid_rdata;
    logic        r_out_valid, r_out_irq, r_out_fiq, r_out_ack, r_out_bad, r_out_use_q;
    logic [31:0] r_out_rdata, r_out_pv;

    logic adv, accept, proc;
    t_req in_req;
    logic [31:0] qa, qb;

    assign adv    = !r_out_valid || m_axis_tready;
    assign accept = s_axis_tvalid && adv;
    assign proc   = r_in_valid && adv;
    assign in_req = t_req'(s_axis_tdata[$bits(t_req)-1:0]);
    assign s_axis_tready = adv;

    // apb
    assign pready = 1'b1;
    assign prdata = (paddr == CFG_CHAIN_PRESENT) ? {31'd0, r_chain_present} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_present <= 1'b0;
        end else if (psel && penable && pwrite && paddr == CFG_CHAIN_PRESENT) begin
            r_chain_present <= pwdata[0];
        end
    end

    // selection tree over the current state
    logic [31:0]       raw_st, irq_st, fiq_st;
    logic              t_v [64];
    logic [PRIO_W-1:0] t_p [64];
    logic [IDX_W-1:0]  t_i [64];
    logic              loc_sel, chn_sel;
    logic [PRIO_W-1:0] best_p;
    logic [IDX_W-1:0]  best_i;

    assign raw_st = (r_line_levels | r_soft_levels) & LINE_MASK;
    assign irq_st = raw_st & r_enable & ~r_fast_sel;
    assign fiq_st = raw_st & r_enable & r_fast_sel;

    always_comb begin
        for (int l = 0; l < 32; l++) begin
            t_p[32+l] = r_prio[l];
            t_i[32+l] = IDX_W'(l);
            t_v[32+l] = irq_st[l] && r_prio_mask[r_prio[l]]
                        && ({1'b0, r_prio[l]} < 5'(r_active));
        end
        t_v[0] = 1'b0;
        t_p[0] = '0;
        t_i[0] = '0;
        for (int n = 31; n >= 1; n--) begin
            if (t_v[2*n] && (!t_v[2*n+1] || t_p[2*n] <= t_p[2*n+1])) begin
                t_v[n] = 1'b1;
                t_p[n] = t_p[2*n];
                t_i[n] = t_i[2*n];
            end else begin
                t_v[n] = t_v[2*n+1];
                t_p[n] = t_p[2*n+1];
                t_i[n] = t_i[2*n+1];
            end
        end
    end

    assign best_p  = t_p[1];
    assign best_i  = t_i[1];
    assign chn_sel = r_chain_irq && r_chain_present && r_prio_mask[r_chain_prio]
                     && ({1'b0, r_chain_prio} < 5'(r_active))
                     && (!t_v[1] || r_chain_prio < best_p);
    assign loc_sel = t_v[1] && !chn_sel;

    // vector table copies: one read by register offset, one by the selected line
    logic            vt_we;
    logic [IDX_W-1:0] vt_waddr;
    logic [IDX_W-1:0] in_vidx;
    logic [MAX_LINES-1:0] r_vt_valid;
    logic            r_qa_ok, r_qb_ok;
    logic [31:0]     qb_m;

    assign in_vidx = in_req.reg_offset[6:2];
    assign qb_m    = r_qb_ok ? qb : 32'd0;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt_valid <= '0;
        end else if (vt_we) begin
            r_vt_valid[vt_waddr] <= 1'b1;
        end
    end

    vic_ram #(.WIDTH(32), .DEPTH(MAX_LINES)) u_vt_reg (
        .i_clk   (i_clk),
        .i_we    (vt_we),
        .i_waddr (vt_waddr),
        .i_wdata (r_in.write_data),
        .i_re    (accept),
        .i_raddr (in_vidx),
        .o_rdata (qa)
    );

    vic_ram #(.WIDTH(32), .DEPTH(MAX_LINES)) u_vt_sel (
        .i_clk   (i_clk),
        .i_we    (vt_we),
        .i_waddr (vt_waddr),
        .i_wdata (r_in.write_data),
        .i_re    (adv),
        .i_raddr (best_i),
        .o_rdata (qb)
    );

    // process stage
    logic [11:0]      off;
    logic [IDX_W-1:0] widx;
    logic             in_vwin, in_pwin, in_idwin, widx_ok;
    logic [31:0]      lv_cur;
    logic             is_ack, is_cpl;
    logic [31:0]      n_rdata;
    logic             n_bad, n_use_q, n_ack;

    assign off      = r_in.reg_offset;
    assign widx     = off[6:2];
    assign in_vwin  = off[11:7] == WIN_VECTOR;
    assign in_pwin  = off[11:7] == WIN_PRIO;
    assign in_idwin = off[11:5] == WIN_ID;
    assign widx_ok  = 32'(widx) < NUM_LINES;
    assign lv_cur   = (r_mid_valid && r_mid_use_q) ? qb_m : r_last_vec;
    assign is_ack   = proc && r_in_op == OP_READ && off == OFF_VECT_ADDR
                      && (loc_sel || chn_sel);
    assign is_cpl   = proc && r_in_op == OP_WRITE && off == OFF_VECT_ADDR;
    assign vt_we    = proc && r_in_op == OP_WRITE && in_vwin && widx_ok;
    assign vt_waddr = widx;

    always_comb begin
        n_rdata = '0;
        n_bad   = 1'b0;
        n_use_q = 1'b0;
        n_ack   = 1'b0;
        if (r_in_op == OP_READ) begin
            if (in_idwin) begin
                n_rdata = {24'd0, id_byte(off[4:2])};
            end else if (in_vwin) begin
                if (widx_ok) begin
                    n_rdata = r_in_byp ? r_byp_data : (r_qa_ok ? qa : 32'd0);
                end else begin
                    n_bad = 1'b1;
                end
            end else if (in_pwin) begin
                if (widx_ok) begin
                    n_rdata = {28'd0, r_prio[widx]};
                end else begin
                    n_bad = 1'b1;
                end
            end else begin
                case (off)
                    OFF_IRQ_STATUS: n_rdata = irq_st;
                    OFF_FIQ_STATUS: n_rdata = fiq_st;
                    OFF_RAW_STATUS: n_rdata = raw_st;
                    OFF_FIQ_SELECT: n_rdata = r_fast_sel;
                    OFF_ENABLE,
                    OFF_ENABLE_CLR: n_rdata = r_enable;
                    OFF_SOFT,
                    OFF_SOFT_CLR:   n_rdata = r_soft_levels;
                    OFF_PROTECT:    n_rdata = {31'd0, r_protect};
                    OFF_PRIO_MASK:  n_rdata = {16'd0, r_prio_mask};
                    OFF_CHAIN_PRIO: n_rdata = {28'd0, r_chain_prio};
                    OFF_VECT_ADDR: begin
                        if (chn_sel) begin
                            n_rdata = r_chain_addr;
                            n_ack   = 1'b1;
                        end else if (loc_sel) begin
                            n_use_q = 1'b1;
                        end else begin
                            n_rdata = lv_cur;
                        end
                    end
                    default: n_bad = 1'b1;
                endcase
            end
        end else if (r_in_op == OP_WRITE) begin
            if (in_vwin || in_pwin) begin
                n_bad = !widx_ok;
            end else begin
                case (off)
                    OFF_FIQ_SELECT, OFF_ENABLE, OFF_ENABLE_CLR, OFF_SOFT, OFF_SOFT_CLR,
                    OFF_PROTECT, OFF_PRIO_MASK, OFF_CHAIN_PRIO, OFF_VECT_ADDR: n_bad = 1'b0;
                    default: n_bad = 1'b1;
                endcase
            end
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_levels <= '0;
            r_soft_levels <= '0;
            r_enable      <= '0;
            r_fast_sel    <= '0;
            r_prio_mask   <= 16'hffff;
            r_chain_prio  <= '1;
            r_protect     <= 1'b0;
            r_active      <= NO_LEVEL;
            r_depth       <= '0;
            r_last_vec    <= '0;
            r_chain_irq   <= 1'b0;
            r_chain_fiq   <= 1'b0;
            r_chain_addr  <= '0;
            for (int l = 0; l < MAX_LINES; l++) begin
                r_prio[l] <= '1;
            end
        end else if (adv) begin
            // a chain acknowledge is younger than a local one in the next stage
            if (is_ack && chn_sel) begin
                r_last_vec <= r_chain_addr;
            end else if (r_mid_valid && r_mid_use_q) begin
                r_last_vec <= qb_m;
            end
            if (proc) begin
                case (r_in_op)
                    OP_LINE: begin
                        if (32'(r_in.line_index) < NUM_LINES) begin
                            r_line_levels[r_in.line_index] <= r_in.line_level;
                        end
                    end
                    OP_WRITE: begin
                        if (in_pwin && widx_ok) begin
                            r_prio[widx] <= r_in.write_data[PRIO_W-1:0];
                        end
                        if (!in_vwin && !in_pwin) begin
                            case (off)
                                OFF_FIQ_SELECT: r_fast_sel <= r_in.write_data & LINE_MASK;
                                OFF_ENABLE:     r_enable <= r_enable
                                                            | (r_in.write_data & LINE_MASK);
                                OFF_ENABLE_CLR: r_enable <= r_enable & ~r_in.write_data;
                                OFF_SOFT:       r_soft_levels <= r_soft_levels
                                                            | (r_in.write_data & LINE_MASK);
                                OFF_SOFT_CLR:   r_soft_levels <= r_soft_levels
                                                            & ~r_in.write_data;
                                OFF_PROTECT:    r_protect <= r_in.write_data[0];
                                OFF_PRIO_MASK:  r_prio_mask <= r_in.write_data[15:0];
                                OFF_CHAIN_PRIO: r_chain_prio <= r_in.write_data[PRIO_W-1:0];
                                default: ;
                            endcase
                        end
                    end
                    OP_CHAIN: begin
                        r_chain_irq  <= r_in.chain_irq;
                        r_chain_fiq  <= r_in.chain_fiq;
                        r_chain_addr <= r_in.chain_vector;
                    end
                    default: ;
                endcase
                if (is_ack) begin
                    if (32'(r_depth) < NUM_LEVELS) begin
                        r_depth <= r_depth + 1'b1;
                    end
                    if (chn_sel) begin
                        r_active <= LVL_W'(r_chain_prio);
                    end else begin
                        r_active <= LVL_W'(best_p);
                    end
                end
                if (is_cpl) begin
                    if (r_depth != '0) begin
                        r_depth  <= r_depth - 1'b1;
                        r_active <= r_stack[$clog2(NUM_LEVELS)'(r_depth - 1'b1)];
                    end else begin
                        r_active <= NO_LEVEL;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_ack && 32'(r_depth) < NUM_LEVELS) begin
            r_stack[$clog2(NUM_LEVELS)'(r_depth)] <= r_active;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid  <= s_axis_tvalid;
            r_mid_valid <= r_in_valid;
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in       <= in_req;
            r_in_op    <= t_opcode'(s_axis_tuser);
            r_in_byp   <= vt_we && vt_waddr == in_vidx;
            r_byp_data <= r_in.write_data;
            r_qa_ok    <= r_vt_valid[in_vidx];
        end
        if (adv) begin
            r_qb_ok     <= r_vt_valid[best_i];
            r_mid_rdata <= n_rdata;
            r_mid_bad   <= n_bad;
            r_mid_use_q <= proc && n_use_q;
            r_mid_ack   <= n_ack;
            r_out_rdata <= r_mid_use_q ? qb_m : r_mid_rdata;
            r_out_bad   <= r_mid_bad;
            r_out_ack   <= r_mid_ack;
            r_out_irq   <= loc_sel || chn_sel;
            r_out_fiq   <= (fiq_st != '0) || r_chain_fiq;
            r_out_use_q <= loc_sel;
            r_out_pv    <= chn_sel ? r_chain_addr : 32'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_bad, r_out_ack, (r_out_use_q ? qb_m : r_out_pv),
                            r_out_fiq, r_out_irq, r_out_rdata};

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= NUM_LEVELS)
        else $error("nesting depth beyond stack size");

    a_idle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth == '0 |-> r_active == NO_LEVEL)
        else $error("empty stack with an active priority");

    a_ack_raises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_ack |=> r_active < $past(r_active))
        else $error("acknowledge did not raise the active priority");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_depth) && $stable(r_active) && $stable(r_enable))
        else $error("state changed during an output stall");

endmodule

// ===== bench/vectored_interrupt_controller_top_test.sv =====
// self-checking testbench of the vectored interrupt controller: directed and random requests
module vectored_interrupt_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vic_pkg::*;

    localparam int NLINES = 32;
    localparam int NLEV = 16;
    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic        bad_access;
        logic        chain_ack;
        logic [31:0] pending_vector;
        logic        fiq_out;
        logic        irq_out;
        logic [31:0] read_data;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    vectored_interrupt_controller_top dut (.*);

    always #5 i_clk = ~i_clk;

    // controller shadow state
    logic        chain_on;
    logic [31:0] lines_q, soft_q, en_q, fsel_q, vect_q [NLINES];
    logic [3:0]  prio_q [NLINES];
    logic [15:0] pmask_q;
    logic [3:0]  cprio_q;
    logic        prot_q;
    logic [4:0]  active_q, stack_q [NLEV];
    logic [4:0]  depth_q;
    logic [31:0] lastv_q;
    logic        c_irq, c_fiq;
    logic [31:0] c_addr;

    t_resp expected_q [$];
    int fails = 0;
    int quiet = 0;
    int send_idle = 0, recv_stall = 0;

    function automatic int pick_request();
        logic [31:0] st;
        int sel;
        logic [3:0] best;
        st = (lines_q | soft_q) & en_q & ~fsel_q;
        sel = -1;
        best = 0;
        for (int i = 0; i < NLINES; i++)
            if (st[i] && pmask_q[prio_q[i]] && {1'b0, prio_q[i]} < active_q &&
                (sel < 0 || prio_q[i] < best)) begin
                sel = i;
                best = prio_q[i];
            end
        if (c_irq && chain_on && pmask_q[cprio_q] && {1'b0, cprio_q} < active_q &&
            (sel < 0 || cprio_q < best))
            return NLINES;
        return sel;
    endfunction

    function automatic logic [31:0] vector_for(int sel);
        if (sel == NLINES) return c_addr;
        if (sel >= 0) return vect_q[sel];
        return 0;
    endfunction

    function automatic void model_reset();
        chain_on = 0;
        lines_q = 0; soft_q = 0; en_q = 0; fsel_q = 0;
        for (int i = 0; i < NLINES; i++) begin
            vect_q[i] = 0;
            prio_q[i] = 4'hf;
        end
        pmask_q = 16'hffff; cprio_q = 4'hf; prot_q = 0;
        active_q = 5'(NLEV);
        for (int i = 0; i < NLEV; i++) stack_q[i] = 0;
        depth_q = 0; lastv_q = 0;
        c_irq = 0; c_fiq = 0; c_addr = 0;
    endfunction

    function automatic t_resp controller_step(t_opcode op, t_req r);
        t_resp o;
        int sel;
        logic [11:0] off;
        logic [31:0] rd;
        logic bad, ack, fiq_any;
        off = r.reg_offset;
        rd = 0; bad = 0; ack = 0;
        case (op)
            OP_LINE: lines_q[r.line_index] = r.line_level;
            OP_READ: begin
                if (off >= 12'hfe0) rd = {24'd0, id_byte(off[4:2])};
                else if (off >= 12'h100 && off < 12'h180) rd = vect_q[off[6:2]];
                else if (off >= 12'h200 && off < 12'h280) rd = {28'd0, prio_q[off[6:2]]};
                else case (off)
                    OFF_IRQ_STATUS: rd = (lines_q | soft_q) & en_q & ~fsel_q;
                    OFF_FIQ_STATUS: rd = (lines_q | soft_q) & en_q & fsel_q;
                    OFF_RAW_STATUS: rd = lines_q | soft_q;
                    OFF_FIQ_SELECT: rd = fsel_q;
                    OFF_ENABLE, OFF_ENABLE_CLR: rd = en_q;
                    OFF_SOFT, OFF_SOFT_CLR: rd = soft_q;
                    OFF_PROTECT: rd = {31'd0, prot_q};
                    OFF_PRIO_MASK: rd = {16'd0, pmask_q};
                    OFF_CHAIN_PRIO: rd = {28'd0, cprio_q};
                    OFF_VECT_ADDR: begin
                        sel = pick_request();
                        if (sel < 0) rd = lastv_q;
                        else begin
                            if (depth_q < NLEV) begin
                                stack_q[depth_q] = active_q;
                                depth_q++;
                            end
                            if (sel == NLINES) begin
                                active_q = {1'b0, cprio_q};
                                ack = 1;
                            end else active_q = {1'b0, prio_q[sel]};
                            rd = vector_for(sel);
                            lastv_q = rd;
                        end
                    end
                    default: bad = 1;
                endcase
            end
            OP_WRITE: begin
                if (off >= 12'h100 && off < 12'h180) vect_q[off[6:2]] = r.write_data;
                else if (off >= 12'h200 && off < 12'h280) prio_q[off[6:2]] = r.write_data[3:0];
                else case (off)
                    OFF_FIQ_SELECT: fsel_q = r.write_data;
                    OFF_ENABLE: en_q |= r.write_data;
                    OFF_ENABLE_CLR: en_q &= ~r.write_data;
                    OFF_SOFT: soft_q |= r.write_data;
                    OFF_SOFT_CLR: soft_q &= ~r.write_data;
                    OFF_PROTECT: prot_q = r.write_data[0];
                    OFF_PRIO_MASK: pmask_q = r.write_data[15:0];
                    OFF_CHAIN_PRIO: cprio_q = r.write_data[3:0];
                    OFF_VECT_ADDR: begin
                        if (depth_q > 0) begin
                            depth_q--;
                            active_q = stack_q[depth_q];
                        end else active_q = 5'(NLEV);
                    end
                    default: bad = 1;
                endcase
            end
            default: begin
                c_irq = r.chain_irq;
                c_fiq = r.chain_fiq;
                c_addr = r.chain_vector;
            end
        endcase
        sel = pick_request();
        fiq_any = (((lines_q | soft_q) & en_q & fsel_q) != 0) || c_fiq;
        o.read_data = rd;
        o.irq_out = sel >= 0;
        o.fiq_out = fiq_any;
        o.pending_vector = vector_for(sel);
        o.chain_ack = ack;
        o.bad_access = bad;
        return o;
    endfunction

    // tvalid stays high between back to back requests and drops while idle
    task automatic send_request(t_opcode op, t_req r);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        expected_q.push_back(controller_step(op, r));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'h0, r};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_req make_req(logic [11:0] off, logic [31:0] wd);
        t_req r;
        r = '0;
        r.reg_offset = off;
        r.write_data = wd;
        return r;
    endfunction

    task automatic reg_wr(logic [11:0] off, logic [31:0] wd);
        send_request(OP_WRITE, make_req(off, wd));
    endtask

    task automatic reg_rd(logic [11:0] off);
        send_request(OP_READ, make_req(off, $urandom));
    endtask

    task automatic set_line(int idx, bit lvl);
        t_req r;
        r = make_req(12'($urandom), $urandom);
        r.line_index = 5'(idx);
        r.line_level = lvl;
        send_request(OP_LINE, r);
    endtask

    task automatic set_chain(bit irq, bit fiq, logic [31:0] vec);
        t_req r;
        r = make_req(12'($urandom), $urandom);
        r.chain_irq = irq;
        r.chain_fiq = fiq;
        r.chain_vector = vec;
        send_request(OP_CHAIN, r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_chain_present(bit v);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= CFG_CHAIN_PRESENT; pwdata <= {31'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        chain_on = v;
    endtask

    task automatic test_directed();
        reg_rd(12'hfe0); reg_rd(12'hffc); reg_rd(12'h17c); reg_rd(12'h27f);
        reg_rd(12'h02c); reg_wr(12'h000, 32'hffffffff); reg_wr(12'hfe4, 0);
        reg_wr(12'h101, 32'hdeadbeef);
        reg_rd(OFF_VECT_ADDR);
        reg_wr(OFF_VECT_ADDR, 0);
        reg_wr(OFF_ENABLE, 32'hffffffff);
        reg_wr(12'h20c, 32'h3);
        reg_wr(12'h10c, 32'h0000_1000);
        reg_wr(OFF_PROTECT, 32'hffffffff);
        reg_wr(OFF_PRIO_MASK, 32'hffff_fff7);
        set_line(3, 1); set_line(31, 1);
        set_chain(1, 1, 32'hffffffff);
        reg_wr(OFF_CHAIN_PRIO, 32'h1);
        reg_rd(OFF_VECT_ADDR);
        reg_rd(OFF_VECT_ADDR);
        reg_wr(OFF_VECT_ADDR, 0);
        reg_wr(OFF_FIQ_SELECT, 32'h8000_0000);
        reg_rd(OFF_FIQ_STATUS);
        reg_wr(OFF_SOFT, 32'hffffffff); reg_wr(OFF_SOFT_CLR, 32'hffffffff);
    endtask

    task automatic test_stack_overflow();
        reg_wr(OFF_PRIO_MASK, 32'hffff);
        for (int i = 0; i < 18; i++) begin
            reg_wr(12'(12'h200 + 4 * i), 32'(15 - (i % 16)));
            reg_wr(12'(12'h100 + 4 * i), $urandom);
            set_line(i, 1'b1);
            reg_rd(OFF_VECT_ADDR);
        end
        repeat (20) reg_wr(OFF_VECT_ADDR, 0);
    endtask

    task automatic random_request();
        t_req r;
        t_opcode op;
        int k;
        r = make_req(12'($urandom), $urandom);
        r.line_index = 5'($urandom);
        r.line_level = 1'($urandom);
        r.chain_irq = 1'($urandom);
        r.chain_fiq = 1'($urandom);
        r.chain_vector = $urandom;
        k = $urandom_range(99);
        if (k < 20) op = OP_LINE;
        else if (k < 30) op = OP_CHAIN;
        else begin
            op = (k < 62) ? OP_READ : OP_WRITE;
            k = $urandom_range(9);
            if (k < 3) r.reg_offset = OFF_VECT_ADDR;
            else if (k < 5) r.reg_offset = 12'(4 * $urandom_range(10));
            else if (k == 5) r.reg_offset = 12'(12'h100 + $urandom_range(127));
            else if (k == 6) begin
                r.reg_offset = 12'(12'h200 + $urandom_range(127));
                r.write_data[3:0] = 4'($urandom_range(15));
            end else if (k == 7) r.reg_offset = 12'(12'hfe0 + $urandom_range(31));
        end
        send_request(op, r);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) random_request();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    always @(posedge i_clk) begin
        t_resp got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_resp'(m_axis_tdata[$bits(t_resp)-1:0]);
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", got);
                fails++;
            end else begin
                want = expected_q.pop_front();
                if (got.read_data !== want.read_data) begin
                    $error("read_data exp %h got %h", want.read_data, got.read_data); fails++;
                end
                if (got.irq_out !== want.irq_out) begin
                    $error("irq_out exp %b got %b", want.irq_out, got.irq_out); fails++;
                end
                if (got.fiq_out !== want.fiq_out) begin
                    $error("fiq_out exp %b got %b", want.fiq_out, got.fiq_out); fails++;
                end
                if (got.pending_vector !== want.pending_vector) begin
                    $error("pending_vector exp %h got %h", want.pending_vector,
                           got.pending_vector);
                    fails++;
                end
                if (got.chain_ack !== want.chain_ack) begin
                    $error("chain_ack exp %b got %b", want.chain_ack, got.chain_ack); fails++;
                end
                if (got.bad_access !== want.bad_access) begin
                    $error("bad_access exp %b got %b", want.bad_access, got.bad_access);
                    fails++;
                end
            end
        end
    end

    // watchdog on requests and results that stop moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
        else if (i_rst_n) quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_chain_present(1);
        test_directed();
        test_stack_overflow();
        test_random(400);
        send_idle = 88;
        test_random(400);
        drain();
        send_idle = 0; recv_stall = 88;
        test_random(400);
        set_chain_present(0);
        send_idle = 18; recv_stall = 18;
        test_random(400);
        set_chain_present(1);
        send_idle = 0; recv_stall = 0;
        test_random(400);
        drain();
        if (fails == 0 && expected_q.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/vic_pkg.sv
rtl/vic_ram.sv
rtl/vectored_interrupt_controller_top.sv
bench/vectored_interrupt_controller_top_test.sv
